>>> hw/rtl/rcdf_pkg.sv
// ----------------------------------------------------------------------------
// rcdf_pkg
// Types, constants and the control store of the recent check value
// duplicate filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rcdf_pkg;

    localparam int CH_W    = 4;
    localparam int CRC_W   = 16;
    localparam int DEPTH_W = 6;
    localparam int TAG_W   = CRC_W + 1;

    // sequencer steps
    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_CHECK,
        S_PRIME,
        S_SCAN,
        S_WRITE,
        S_RESULT
    } t_step;

    // jump conditions
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN,
        C_SKIP,
        C_SCAN,
        C_OUT,
        C_CLR
    } t_cond;

    typedef struct packed {
        t_cond cond;
        t_step tgt_t;
        t_step tgt_f;
        logic  ld_in;
        logic  rd;
        logic  scan;
        logic  wr;
        logic  ld_out;
        logic  clr;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic skip;
        logic scan_end;
        logic out_free;
        logic clr_done;
    } t_ustat;

    // control store
    function automatic t_uword urom(input t_step s);
        t_uword w;
        w = '{cond: C_ALWAYS, tgt_t: S_IDLE, tgt_f: S_IDLE, ld_in: 1'b0, rd: 1'b0,
              scan: 1'b0, wr: 1'b0, ld_out: 1'b0, clr: 1'b0};
        case (s)
            S_CLR: begin
                w.cond  = C_CLR;
                w.tgt_t = S_IDLE;
                w.tgt_f = S_CLR;
                w.clr   = 1'b1;
            end
            S_IDLE: begin
                w.cond  = C_IN;
                w.tgt_t = S_CHECK;
                w.tgt_f = S_IDLE;
                w.ld_in = 1'b1;
            end
            S_CHECK: begin
                w.cond  = C_SKIP;
                w.tgt_t = S_RESULT;
                w.tgt_f = S_PRIME;
            end
            S_PRIME: begin
                w.cond  = C_ALWAYS;
                w.tgt_t = S_SCAN;
                w.tgt_f = S_SCAN;
                w.rd    = 1'b1;
            end
            S_SCAN: begin
                w.cond  = C_SCAN;
                w.tgt_t = S_WRITE;
                w.tgt_f = S_SCAN;
                w.rd    = 1'b1;
                w.scan  = 1'b1;
            end
            S_WRITE: begin
                w.cond  = C_ALWAYS;
                w.tgt_t = S_RESULT;
                w.tgt_f = S_RESULT;
                w.wr    = 1'b1;
            end
            S_RESULT: begin
                w.cond   = C_OUT;
                w.tgt_t  = S_IDLE;
                w.tgt_f  = S_RESULT;
                w.ld_out = 1'b1;
            end
            default: begin
                w.cond  = C_ALWAYS;
                w.tgt_t = S_CLR;
                w.tgt_f = S_CLR;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rcdf_ram.sv
// ----------------------------------------------------------------------------
// rcdf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rcdf_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/rcdf_useq.sv
// ----------------------------------------------------------------------------
// rcdf_useq
// Step counter and control store; conditional jumps on datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

module rcdf_useq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire rcdf_pkg::t_ustat i_stat,
    output rcdf_pkg::t_uword     o_uw,
    output rcdf_pkg::t_step      o_step
);

    rcdf_pkg::t_step  r_step;
    rcdf_pkg::t_step  n_step;
    rcdf_pkg::t_uword w_uw;
    logic             w_take;

    assign w_uw = rcdf_pkg::urom(r_step);

    // next step
    always_comb begin
        case (w_uw.cond)
            rcdf_pkg::C_ALWAYS: w_take = 1'b1;
            rcdf_pkg::C_IN:     w_take = i_stat.in_valid;
            rcdf_pkg::C_SKIP:   w_take = i_stat.skip;
            rcdf_pkg::C_SCAN:   w_take = i_stat.scan_end;
            rcdf_pkg::C_OUT:    w_take = i_stat.out_free;
            rcdf_pkg::C_CLR:    w_take = i_stat.clr_done;
            default:            w_take = 1'b1;
        endcase
        n_step = w_take ? w_uw.tgt_t : w_uw.tgt_f;
    end

    // control outputs
    always_comb begin
        o_uw   = w_uw;
        o_step = r_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= rcdf_pkg::S_CLR;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/recent_crc_duplicate_filter_top.sv
// ----------------------------------------------------------------------------
// recent_crc_duplicate_filter_top
// Per-channel history of recent tagged check values; flags repeated frames.
// ----------------------------------------------------------------------------
// after reset a clearing pass zeroes all NUM_CHANNELS*RING_DEPTH history
// entries (512 by default), taking no transaction meanwhile; each input then
// passes check, prime, k scan steps, write and result, k = entries compared
// (1..min(dup_depth,RING_DEPTH)); check goes straight to result when checking
// is off or the channel is out of range; the next input is taken after result
// throughput: one compare per cycle, set by the single history RAM read port
`default_nettype none

module recent_crc_duplicate_filter_top #(
    parameter int NUM_CHANNELS = 16,
    parameter int RING_DEPTH   = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [5:0]  i_cfg_wdata,     // dup_depth
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,  // channel[3:0], crc_value[19:4]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata   // is_duplicate[0]
);

    localparam int TOTAL = NUM_CHANNELS * RING_DEPTH;
    localparam int AW    = $clog2(TOTAL);
    localparam int RPW   = $clog2(RING_DEPTH);
    localparam int RW    = $clog2(RING_DEPTH + 1);
    localparam int CIW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    rcdf_pkg::t_uword w_uw;
    rcdf_pkg::t_ustat w_stat;
    rcdf_pkg::t_step  w_step;

    logic [rcdf_pkg::DEPTH_W-1:0] r_depth;
    logic [RPW-1:0]               r_wptr [NUM_CHANNELS];
    logic [CIW-1:0]               r_ch;
    logic [AW-1:0]                r_base;
    logic [rcdf_pkg::TAG_W-1:0]   r_tag;
    logic [RPW-1:0]               r_wp0;
    logic [RPW-1:0]               r_pos;
    logic [RW-1:0]                r_rem;
    logic                         r_skip;
    logic                         r_hit;
    logic [AW-1:0]                r_clr;
    logic                         r_out_valid;
    logic                         r_out_dup;

    logic [rcdf_pkg::CH_W-1:0]    w_ch_in;
    logic [CIW+rcdf_pkg::CH_W-1:0] w_ch_ext;
    logic [CIW-1:0]               w_idx_in;
    logic                         w_in_range;
    logic                         w_accept;
    logic                         w_match;
    logic [RPW-1:0]               w_wp_next;
    logic [AW-1:0]                w_raddr;
    logic [AW-1:0]                w_waddr;
    logic [rcdf_pkg::TAG_W-1:0]   w_wdata;
    logic                         w_we;
    logic [rcdf_pkg::TAG_W-1:0]   w_rdata;

    rcdf_useq u_useq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (w_stat),
        .o_uw   (w_uw),
        .o_step (w_step)
    );

    rcdf_ram #(
        .WIDTH(rcdf_pkg::TAG_W),
        .DEPTH(TOTAL)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_ch_in    = i_s_axis_tdata[rcdf_pkg::CH_W-1:0];
    assign w_ch_ext   = {{CIW{1'b0}}, w_ch_in};
    assign w_idx_in   = w_ch_ext[CIW-1:0];
    assign w_in_range = (32'(w_ch_in) < NUM_CHANNELS);
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_match    = (w_rdata == r_tag);
    assign w_wp_next  = (r_wp0 == RPW'(RING_DEPTH - 1)) ? '0 : r_wp0 + 1'b1;
    assign w_raddr    = r_base + AW'(r_pos);

    always_comb begin
        if (w_uw.clr) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else begin
            w_we    = w_uw.wr;
            w_waddr = r_base + AW'(w_wp_next);
            w_wdata = r_hit ? '0 : r_tag;
        end
    end

    always_comb begin
        w_stat.in_valid = i_s_axis_tvalid;
        w_stat.skip     = r_skip;
        w_stat.scan_end = w_match || (r_rem == RW'(1));
        w_stat.out_free = !r_out_valid || i_m_axis_tready;
        w_stat.clr_done = (r_clr == AW'(TOTAL - 1));
    end

    assign o_s_axis_tready = w_uw.ld_in;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_out_dup};

    // configuration and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_wptr[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_depth <= i_cfg_wdata;
            end
            if (w_uw.clr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_uw.wr) begin
                r_wptr[r_ch] <= w_wp_next;
            end
            if (w_uw.ld_out && w_stat.out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // per-transaction datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch   <= w_in_range ? w_idx_in : '0;
            r_base <= w_in_range ? AW'(32'(w_idx_in) * RING_DEPTH) : '0;
            r_tag  <= {1'b1, i_s_axis_tdata[rcdf_pkg::CH_W +: rcdf_pkg::CRC_W]};
            r_wp0  <= w_in_range ? r_wptr[w_idx_in] : '0;
            r_pos  <= w_in_range ? r_wptr[w_idx_in] : '0;
            r_rem  <= (32'(r_depth) > RING_DEPTH) ? RW'(RING_DEPTH) : RW'(r_depth);
            r_skip <= !w_in_range || (r_depth == '0);
            r_hit  <= 1'b0;
        end else begin
            if (w_uw.rd) begin
                r_pos <= (r_pos == '0) ? RPW'(RING_DEPTH - 1) : r_pos - 1'b1;
            end
            if (w_uw.scan) begin
                r_hit <= w_match;
                r_rem <= r_rem - 1'b1;
            end
        end
        if (w_uw.ld_out && w_stat.out_free) begin
            r_out_dup <= r_hit;
        end
    end

    a_rise_from_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_step) == rcdf_pkg::S_RESULT)
        else $error("result appeared outside the result step");

    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_step == rcdf_pkg::S_CHECK)
        else $error("accepted transaction not followed by check step");

    a_dup_needs_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[0] |-> r_depth != '0)
        else $error("duplicate reported with checking disabled");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step == rcdf_pkg::S_CLR |-> !o_s_axis_tready)
        else $error("input taken during clearing pass");

endmodule

`default_nettype wire
